[rtl/tws_pkg.sv]
// Shared types and constants for the textured wall column shader.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package tws_pkg;

    // Default geometry of the texture store and screen
    localparam int TEX_SIZE_DEF  = 64;
    localparam int TEX_COUNT_DEF = 8;
    localparam int MAX_ROWS_DEF  = 1024;

    // Shared divider widths: widest dividend is the hit product magnitude
    localparam int DIV_W = 44;
    localparam int DVS_W = 24;
    localparam int CNT_W = 6;

    // Opcodes of an input word
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_ROW   = 2'd2;

    localparam logic [10:0] SCREEN_H_RESET = 11'd480;
    localparam logic [23:0] DARK_MASK      = 24'h7F7F7F;
    localparam logic [15:0] HEIGHT_MAX     = 16'hFFFF;

    // Request to the shared divider
    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] dividend;   // left aligned
        logic [DVS_W-1:0] divisor;
        logic [CNT_W-1:0] count;      // number of quotient bits
    } t_div_req;

    // Answer of the shared divider
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } t_div_rsp;

endpackage
`default_nettype wire

[rtl/tws_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tws_pkg for widths and request/answer types.
`timescale 1ns / 1ps
`default_nettype none
module tws_divider
    import tws_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_run, n_run;
    logic             r_done, n_done;

    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] diff;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        shifted = {r_rem, r_quo[DIV_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
    end

    // Advance one bit per cycle
    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_req.go) begin
            n_rem = '0;
            n_quo = i_req.dividend;
            n_cnt = i_req.count;
            n_run = 1'b1;
        end else if (r_run) begin
            if (diff[DVS_W+1]) begin
                n_rem = shifted[DVS_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end else begin
                n_rem = diff[DVS_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_req.go) begin
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule
`default_nettype wire

[rtl/tws_tex_mem.sv]
// Texture store: one write port, one registered read port.
// Depends on tws_pkg for the default texture geometry that sets its depth.
`timescale 1ns / 1ps
`default_nettype none
module tws_tex_mem
    import tws_pkg::*;
#(
    parameter int DEPTH = TEX_COUNT_DEF * TEX_SIZE_DEF * TEX_SIZE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire           i_clk,
    input  wire           i_we,
    input  wire  [AW-1:0] i_waddr,
    input  wire  [23:0]   i_wdata,
    input  wire           i_re,
    input  wire  [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);

    logic [23:0] r_mem [0:DEPTH-1];

    // Write a texel
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read a texel, data registered and shown in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/textured_wall_column_shader.sv]
// Textured wall column shader: sequencer around a shared divider and texture store.
// Depends on tws_pkg, tws_divider and tws_tex_mem.
//
// Usage: a word on the input ports is taken at a clock edge with start high and
// busy low. Opcode load writes one texel when texture index and texel address
// are in range (busy stays low). Opcode start works out line height, clipped
// span and texture column in turn: the divider gives the height, the span is
// registered, the hit product is formed and divided by the direction along
// the hit axis (skipped when that direction is zero); busy stays high meanwhile.
// Opcode row gives one result word: o_valid is high for exactly one cycle with
// o_pixel_color and o_in_span. A row outside the span, at zero height or with
// a texture index out of range gets a zero colour from the check state; a row
// inside the span runs a divider quotient for the texture row, then a texture
// read, then its word. All divisions use the single radix-2 divider. The receiver
// cannot stall: results are shown once.
// Opcode 3 is taken and ignored. Screen height is written through i_cfg_we and
// i_cfg_data; the user must write it only while the block is idle, which the
// block does not enforce. Synchronous reset clears the sequencer and column
// registers and sets screen height to 480; texture store is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module textured_wall_column_shader
    import tws_pkg::*;
#(
    parameter int TEX_SIZE  = TEX_SIZE_DEF,
    parameter int TEX_COUNT = TEX_COUNT_DEF,
    parameter int MAX_ROWS  = MAX_ROWS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire         [10:0] i_cfg_data,
    input  wire                start,
    output logic               busy,
    input  wire         [1:0]  i_opcode,
    input  wire         [2:0]  i_tex_index,
    input  wire         [11:0] i_texel_addr,
    input  wire         [23:0] i_texel_value,
    input  wire                i_side,
    input  wire         [7:0]  i_hit_cell,
    input  wire         [23:0] i_ray_pos_x,
    input  wire         [23:0] i_ray_pos_y,
    input  wire  signed [17:0] i_ray_dir_x,
    input  wire  signed [17:0] i_ray_dir_y,
    input  wire         [23:0] i_perp_dist,
    input  wire         [9:0]  i_row,
    output logic               o_valid,
    output logic        [23:0] o_pixel_color,
    output logic               o_in_span
);

    localparam int LOG_T    = $clog2(TEX_SIZE);
    localparam int TEX_AREA = TEX_SIZE * TEX_SIZE;
    localparam int DEPTH    = TEX_COUNT * TEX_AREA;
    localparam int AW       = $clog2(DEPTH);
    localparam int RW       = $clog2(MAX_ROWS);
    localparam int H_BITS   = 27;
    localparam int ROW_BITS = 24 + LOG_T;
    localparam logic [12:0] MAX_ROWS_C = 13'(MAX_ROWS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HDIV = 4'd1;
    localparam logic [3:0] S_SPAN = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_HGO  = 4'd4;
    localparam logic [3:0] S_HIT  = 4'd5;
    localparam logic [3:0] S_RCHK = 4'd6;
    localparam logic [3:0] S_RDIV = 4'd7;
    localparam logic [3:0] S_RMEM = 4'd8;

    logic [3:0]        r_state;
    logic [10:0]       r_scr_h;
    logic [2:0]        r_col_tex;
    logic [LOG_T-1:0]  r_col_u;
    logic              r_col_dark;
    logic [15:0]       r_height;
    logic [RW-1:0]     r_span_start;
    logic [RW-1:0]     r_span_end;

    // Latched start and row words
    logic              r_side;
    logic [7:0]        r_cell;
    logic [23:0]       r_px, r_py, r_dist;
    logic signed [17:0] r_dx, r_dy;
    logic [2:0]        r_tex_in;
    logic [9:0]        r_row;
    logic signed [43:0] r_prod;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic accept;
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Clamp screen height to the supported row range
    logic [10:0] eff_h;
    always_comb begin
        if (r_scr_h < 11'd2) begin
            eff_h = 11'd2;
        end else if ({2'b00, r_scr_h} > MAX_ROWS_C) begin
            eff_h = MAX_ROWS_C[10:0];
        end else begin
            eff_h = r_scr_h;
        end
    end

    // Texel load path
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    assign mem_we = accept && (i_opcode == OP_LOAD)
                    && (32'(i_tex_index) < TEX_COUNT) && (32'(i_texel_addr) < TEX_AREA);
    assign mem_waddr = AW'((32'(i_tex_index) << (2 * LOG_T)) | 32'(i_texel_addr));

    // Height quotient saturation
    logic [15:0] height_sat;
    assign height_sat = ((r_dist == '0) || (div_rsp.quotient > DIV_W'(HEIGHT_MAX)))
                        ? HEIGHT_MAX : div_rsp.quotient[15:0];

    // Span from height and screen height
    logic [15:0] half_h, half_l, end_sum;
    logic [RW-1:0] span_start_c, span_end_c;
    always_comb begin
        half_h  = 16'(eff_h >> 1);
        half_l  = r_height >> 1;
        end_sum = half_l + half_h;
        span_start_c = (half_h >= half_l) ? RW'(half_h - half_l) : '0;
        span_end_c   = (end_sum >= 16'(eff_h)) ? RW'(eff_h - 11'd1) : RW'(end_sum);
    end

    // Hit geometry: along axis is the axis of the hit side
    logic [23:0]        along_pos, cross_pos;
    logic signed [17:0] along_dir, cross_dir;
    logic [8:0]         cell_adj;
    logic signed [25:0] num;
    logic [17:0]        dir_mag;
    logic [43:0]        prod_mag;
    always_comb begin
        along_pos = r_side ? r_py : r_px;
        cross_pos = r_side ? r_px : r_py;
        along_dir = r_side ? r_dy : r_dx;
        cross_dir = r_side ? r_dx : r_dy;
        cell_adj  = {1'b0, r_cell} + {8'd0, along_dir[17]};
        num       = $signed({1'b0, cell_adj, 16'd0}) - $signed({2'b00, along_pos});
        dir_mag   = along_dir[17] ? 18'(-along_dir) : 18'(along_dir);
        prod_mag  = r_prod[43] ? 44'(-r_prod) : 44'(r_prod);
    end

    // Floor quotient low bits and texture column
    logic [15:0]      q_lo, hit_lo;
    logic             q_neg;
    logic [LOG_T-1:0] u_raw, u_fin;
    logic             mirror;
    always_comb begin
        q_neg = r_prod[43] ^ along_dir[17];
        if (!q_neg) begin
            q_lo = div_rsp.quotient[15:0];
        end else if (div_rsp.remainder != '0) begin
            q_lo = ~div_rsp.quotient[15:0];
        end else begin
            q_lo = 16'(-div_rsp.quotient[15:0]);
        end
        hit_lo = cross_pos[15:0] + q_lo;
        mirror = (!r_side && !r_dx[17] && (r_dx != '0)) || (r_side && r_dy[17]);
        u_raw  = (r_state == S_MUL) ? '0 : hit_lo[15 -: LOG_T];
        u_fin  = mirror ? ~u_raw : u_raw;
    end

    // Row offset into the wall and span check
    logic signed [24:0] d_raw;
    logic [23:0]        d_clamp;
    logic               row_in, row_skip;
    always_comb begin
        d_raw   = $signed(25'({r_row, 8'd0})) + $signed(25'({r_height, 7'd0}))
                  - $signed(25'({eff_h, 7'd0}));
        d_clamp = d_raw[24] ? 24'd0 : d_raw[23:0];
        row_in  = (RW'(r_row) >= r_span_start) && (RW'(r_row) < r_span_end)
                  && (16'(r_row) < 16'(MAX_ROWS));
        row_skip = !row_in || (r_height == '0) || (32'(r_col_tex) >= TEX_COUNT);
    end

    // Texture row from the quotient, clamped to the last row
    logic [DIV_W-9:0] ty_full;
    logic [LOG_T-1:0] ty;
    logic [AW-1:0]    mem_raddr;
    always_comb begin
        ty_full   = div_rsp.quotient[DIV_W-1:8];
        ty        = (ty_full > (DIV_W-8)'(TEX_SIZE - 1)) ? LOG_T'(TEX_SIZE - 1)
                    : ty_full[LOG_T-1:0];
        mem_raddr = AW'((32'(r_col_tex) << (2 * LOG_T)) | (32'(ty) << LOG_T) | 32'(r_col_u));
    end

    // Divider requests from the sequencer
    always_comb begin
        div_req = '0;
        case (r_state)
            S_IDLE: begin
                div_req.go       = accept && (i_opcode == OP_START);
                div_req.dividend = DIV_W'({eff_h, 16'd0}) << (DIV_W - H_BITS);
                div_req.divisor  = i_perp_dist;
                div_req.count    = CNT_W'(H_BITS);
            end
            S_HGO: begin
                div_req.go       = 1'b1;
                div_req.dividend = prod_mag;
                div_req.divisor  = DVS_W'(dir_mag);
                div_req.count    = CNT_W'(DIV_W);
            end
            S_RCHK: begin
                div_req.go       = !row_skip;
                div_req.dividend = DIV_W'({d_clamp, {LOG_T{1'b0}}}) << (DIV_W - ROW_BITS);
                div_req.divisor  = DVS_W'(r_height);
                div_req.count    = CNT_W'(ROW_BITS);
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    logic [23:0] tex_data;
    logic        mem_re;
    assign mem_re = (r_state == S_RDIV) && div_rsp.done;

    // Sequencer and column registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_scr_h      <= SCREEN_H_RESET;
            r_col_tex    <= '0;
            r_col_u      <= '0;
            r_col_dark   <= 1'b0;
            r_height     <= '0;
            r_span_start <= '0;
            r_span_end   <= '0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_scr_h <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_opcode == OP_START)) begin
                        r_state <= S_HDIV;
                    end else if (accept && (i_opcode == OP_ROW)) begin
                        r_state <= S_RCHK;
                    end
                end
                S_HDIV: begin
                    if (div_rsp.done) begin
                        r_height <= height_sat;
                        r_state  <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    r_span_start <= span_start_c;
                    r_span_end   <= span_end_c;
                    r_state      <= S_MUL;
                end
                S_MUL: begin
                    if (along_dir == '0) begin
                        r_col_u    <= u_fin;
                        r_col_tex  <= r_tex_in;
                        r_col_dark <= r_side;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_HGO;
                    end
                end
                S_HGO: begin
                    r_state <= S_HIT;
                end
                S_HIT: begin
                    if (div_rsp.done) begin
                        r_col_u    <= u_fin;
                        r_col_tex  <= r_tex_in;
                        r_col_dark <= r_side;
                        r_state    <= S_IDLE;
                    end
                end
                S_RCHK: begin
                    if (row_skip) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_RMEM;
                    end
                end
                S_RMEM: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Hold input words and products; fill result payload
    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == OP_START)) begin
            r_side   <= i_side;
            r_cell   <= i_hit_cell;
            r_px     <= i_ray_pos_x;
            r_py     <= i_ray_pos_y;
            r_dx     <= i_ray_dir_x;
            r_dy     <= i_ray_dir_y;
            r_dist   <= i_perp_dist;
            r_tex_in <= i_tex_index;
        end
        if (accept && (i_opcode == OP_ROW)) begin
            r_row <= i_row;
        end
        if (r_state == S_MUL) begin
            r_prod <= num * cross_dir;
        end
        if (r_state == S_RCHK) begin
            o_pixel_color <= '0;
            o_in_span     <= row_in;
        end else if (r_state == S_RMEM) begin
            o_pixel_color <= r_col_dark ? ((tex_data >> 1) & DARK_MASK) : tex_data;
            o_in_span     <= 1'b1;
        end
    end

    tws_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tws_tex_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_texel_value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (tex_data)
    );

endmodule
`default_nettype wire
